>>> rtl/core/ovtr_pkg.sv
// Shared types and constants for the overcurrent trip and recovery monitor.
package ovtr_pkg;

    localparam int MV_W       = 16;
    localparam int PERIOD_W   = 10;
    localparam int TIMER_W    = 20;
    localparam int LEVEL_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TRIP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY = 2'd3;

    // Configuration reset values.
    localparam logic [MV_W-1:0]     TRIP_RST     = 16'hFFFF;
    localparam logic [MV_W-1:0]     CLEAR_RST    = 16'h0000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 10'd10;
    localparam logic [TIMER_W-1:0]  RECOVERY_RST = 20'd5000;

    // Result event codes.
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_TRIP     = 2'd1;
    localparam logic [1:0] EV_RESTORE  = 2'd2;
    localparam logic [1:0] EV_STAY_OFF = 2'd3;

    typedef struct packed {
        logic              command;
        logic [MV_W-1:0]   sample_mv;
        logic              sample_valid;
        logic              pin_ok;
        logic              light_on;
        logic [LEVEL_W-1:0] light_level;
        logic [MV_W-1:0]   light_ct;
    } t_in_item;

    typedef struct packed {
        logic               fault_active;
        logic [MV_W-1:0]    average_mv;
        logic [1:0]         event_res;
        logic               restore_on;
        logic [LEVEL_W-1:0] restore_level;
        logic [MV_W-1:0]    restore_ct;
    } t_out_item;

    typedef struct packed {
        logic               on;
        logic [LEVEL_W-1:0] level;
        logic [MV_W-1:0]    ct;
    } t_snapshot;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_ring_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> rtl/core/ovtr_ring.sv
// Sample ring memory with fill count, write slot and running sum.
module ovtr_ring
    import ovtr_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int CNT_W = 4,
    parameter int SUM_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ring_ctrl       i_ctrl,
    input  logic [MV_W-1:0]  i_sample,
    output logic [SUM_W-1:0] o_sum,
    output logic [CNT_W-1:0] o_fill
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [MV_W-1:0]  r_mem [DEPTH];
    logic [MV_W-1:0]  r_old;
    logic [IDX_W-1:0] r_slot;
    logic [CNT_W-1:0] r_fill;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic             full;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd) begin
            r_old <= r_mem[r_slot];
        end
        if (i_ctrl.wr) begin
            r_mem[r_slot] <= i_sample;
        end
    end

    assign full = (r_fill == CNT_W'(DEPTH));

    // Once the ring is full the overwritten entry leaves the sum.
    always_comb begin
        n_sum = r_sum + SUM_W'(i_sample);
        if (full) begin
            n_sum = n_sum - SUM_W'(r_old);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else if (i_ctrl.wr) begin
            r_sum  <= n_sum;
            r_slot <= (r_slot == IDX_W'(DEPTH - 1)) ? '0 : r_slot + 1'b1;
            if (!full) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    assign o_sum  = r_sum;
    assign o_fill = r_fill;

endmodule

>>> rtl/core/ovtr_div.sv
// Restoring divider that produces one quotient bit per cycle.
module ovtr_div
    import ovtr_pkg::*;
#(
    parameter int DVD_W = 20,
    parameter int DVS_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CTR_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CTR_W-1:0] r_cnt;
    logic             r_done;
    logic [DVS_W:0]   rem_sh;
    logic             take;

    assign rem_sh = {r_rem, r_quo[DVD_W-1]};
    assign take   = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DVD_W-2:0], take};
            r_rem <= take ? DVS_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CTR_W'(1)) && !i_start;
            if (i_start) begin
                r_cnt <= CTR_W'(DVD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

>>> rtl/core/overcurrent_trip_recover_monitor.sv
// Top level: moving-average overcurrent latch with timed recovery and light restore.
//
//  Channel   Ports                        Direction  Moves
//  input     i_valid, o_stall, i_in       in         one sample or trip transaction
//  output    o_valid, i_stall, o_out      out        one result per input transaction
//  config    i_cfg_we, i_cfg_idx, i_cfg_data  in    register write, no wait
//
// A valid sample passes these steps from acceptance to the next: the accepting cycle, one
// ring read, one sum update and write-back, one divider start, SUM_W divider steps, taking the
// quotient into the average register and one result cycle. Trip events and invalid samples go
// straight from acceptance to the result. Reset clears all control state; a ring entry enters
// the sum only once written. One transaction is in work at a time; a finished result waits in
// the output register while the next transaction is accepted.
module overcurrent_trip_recover_monitor
    import ovtr_pkg::*;
#(
    parameter int AVG_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W = MV_W + CNT_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_ACC  = 6'b000100,
        ST_DST  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_EMIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [MV_W-1:0]     r_trip;
    logic [MV_W-1:0]     r_clear;
    logic [PERIOD_W-1:0] r_period;
    logic [TIMER_W-1:0]  r_recovery;

    t_in_item            r_item;
    logic [MV_W-1:0]     r_avg;
    logic                r_fault;
    logic [TIMER_W-1:0]  r_timer;
    logic                r_snap_valid;
    t_snapshot           r_snap;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                n_fault;
    logic [TIMER_W-1:0]  n_timer;
    logic                n_snap_valid;
    t_snapshot           n_snap;
    t_out_item           n_out;

    logic                in_acc;
    logic                out_free;
    logic                out_load;
    logic [TIMER_W:0]    t_sum;
    logic [TIMER_W-1:0]  t_sat;

    t_ring_ctrl          ring_ctrl;
    logic [SUM_W-1:0]    ring_sum;
    logic [CNT_W-1:0]    ring_fill;
    t_div_stat           div_stat;
    logic [SUM_W-1:0]    div_quo;

    ovtr_ring #(
        .DEPTH (AVG_DEPTH),
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ring_ctrl),
        .i_sample (r_item.sample_mv),
        .o_sum    (ring_sum),
        .o_fill   (ring_fill)
    );

    ovtr_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_DST),
        .i_dividend (ring_sum),
        .i_divisor  (ring_fill),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    assign ring_ctrl.rd = (r_state == ST_RD);
    assign ring_ctrl.wr = (r_state == ST_ACC);

    assign o_stall  = (r_state != ST_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign out_load = (r_state == ST_EMIT) && out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trip     <= TRIP_RST;
            r_clear    <= CLEAR_RST;
            r_period   <= PERIOD_RST;
            r_recovery <= RECOVERY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRIP:     r_trip     <= i_cfg_data[MV_W-1:0];
                CFG_CLEAR:    r_clear    <= i_cfg_data[MV_W-1:0];
                CFG_PERIOD:   r_period   <= i_cfg_data[PERIOD_W-1:0];
                CFG_RECOVERY: r_recovery <= i_cfg_data[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.command || !i_in.sample_valid) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD:   n_state = ST_ACC;
            ST_ACC:  n_state = ST_DST;
            ST_DST:  n_state = ST_DIV;
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Recovery timer step, saturating at the top of its range.
    assign t_sum = {1'b0, r_timer} + (TIMER_W + 1)'(r_period);
    assign t_sat = t_sum[TIMER_W] ? '1 : t_sum[TIMER_W-1:0];

    always_comb begin
        n_fault      = r_fault;
        n_timer      = r_timer;
        n_snap_valid = r_snap_valid;
        n_snap       = r_snap;
        n_out        = '0;
        n_out.event_res = EV_NONE;

        if (r_item.command) begin
            if (!r_fault) begin
                n_fault = 1'b1;
                n_timer = '0;
                n_out.event_res = EV_TRIP;
                if (!r_snap_valid) begin
                    n_snap_valid = 1'b1;
                    n_snap.on    = r_item.light_on;
                    n_snap.level = r_item.light_level;
                    n_snap.ct    = r_item.light_ct;
                end
            end
        end else if (!r_item.sample_valid) begin
            n_timer = '0;
        end else if (r_fault) begin
            if ((r_avg <= r_clear) && r_item.pin_ok) begin
                n_timer = t_sat;
                if (t_sat >= r_recovery) begin
                    n_fault = 1'b0;
                    n_timer = '0;
                    if (r_snap_valid) begin
                        n_snap_valid        = 1'b0;
                        n_out.event_res     = EV_RESTORE;
                        n_out.restore_on    = r_snap.on;
                        n_out.restore_level = r_snap.level;
                        n_out.restore_ct    = r_snap.ct;
                    end else begin
                        n_out.event_res = EV_STAY_OFF;
                    end
                end
            end else begin
                n_timer = '0;
            end
        end else if (r_avg > r_trip) begin
            n_fault = 1'b1;
            n_timer = '0;
            n_out.event_res = EV_TRIP;
            if (!r_snap_valid) begin
                n_snap_valid = 1'b1;
                n_snap.on    = r_item.light_on;
                n_snap.level = r_item.light_level;
                n_snap.ct    = r_item.light_ct;
            end
        end

        n_out.fault_active = n_fault;
        n_out.average_mv   = r_avg;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in;
        end
        if (out_load) begin
            r_out  <= n_out;
            r_snap <= n_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_avg        <= '0;
            r_fault      <= 1'b0;
            r_timer      <= '0;
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_DIV) && div_stat.done) begin
                r_avg <= div_quo[MV_W-1:0];
            end
            if (out_load) begin
                r_fault      <= n_fault;
                r_timer      <= n_timer;
                r_snap_valid <= n_snap_valid;
                r_out_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_fill <= CNT_W'(AVG_DEPTH))
        else $error("ring fill count exceeds the ring depth");

    a_snap_needs_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snap_valid |-> r_fault)
        else $error("snapshot held while no fault is latched");

    a_recover_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (n_out.event_res == EV_RESTORE || n_out.event_res == EV_STAY_OFF))
        |=> (!r_fault && r_timer == '0 && !r_snap_valid))
        else $error("recovery left fault, timer or snapshot set");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == ST_DIV))
        else $error("divider running outside its state");

endmodule
